### rtl/fldt_pkg.sv
// Fault log dedup table: shared record types and field widths.
// No dependencies; imported by the top level.
package fldt_pkg;

   localparam int KeyW   = 64;
   localparam int CountW = 32;

   typedef logic [KeyW-1:0]   key_type;
   typedef logic [CountW-1:0] count_type;

   typedef struct packed {
      key_type   key;
      count_type count;
   } record_type;

   localparam int RecW = $bits(record_type);

endpackage

### rtl/fldt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
module fldt_ram #(
   parameter int Width = 96,
   parameter int Depth = 10
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  logic [Width-1:0]                         wr_data,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic [Width-1:0]                         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/fault_log_dedup_table_core.sv
// Fault log dedup table: top level with the scan sequencer and output register.
// Depends on fldt_pkg and fldt_ram.
//
// Deduplicating fault log of up to MAX_ENTRIES records, kept as a ring in one
// RAM (a head pointer marks the oldest record, so eviction never moves data).
// A report word is compared against the held records one per cycle by a
// single 64-bit key comparator walking the RAM from the oldest record. A
// report compares n records, stopping at a match or the end of the log (n = 0
// on an empty log, at most MAX_ENTRIES), then updates or appends one record;
// a clear word, or any word while halted, skips the scan. The input is stalled
// while a word is in work. Results leave through an output register, so a new
// word can be taken while the previous result still waits; the sequencer only
// holds if its next result finds that register still occupied. No clearing
// pass is needed after reset: only records below the fill count are read.
module fault_log_dedup_table_core
   import fldt_pkg::*;
#(
   parameter int MAX_ENTRIES = 10
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_module_id,
   input  logic [7:0]  req_fault_code,
   input  logic [15:0] req_line_number,
   input  logic [31:0] req_extra_word,
   input  logic        req_critical,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_matched,
   output logic [3:0]  rsp_slot,
   output logic [31:0] rsp_occurrences,
   output logic        rsp_evicted,
   output logic [3:0]  rsp_entries_used,
   output logic        rsp_halted
);

   localparam int IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int OccW = $clog2(MAX_ENTRIES + 1);

   localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_ENTRIES - 1);
   localparam logic [OccW-1:0] FullOcc = OccW'(MAX_ENTRIES);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_UPDATE = 3'd2;
   localparam logic [2:0] ST_APPEND = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   function automatic logic [IdxW-1:0] ring_next(input logic [IdxW-1:0] p);
      ring_next = (p == LastIdx) ? '0 : p + IdxW'(1);
   endfunction

   // control state
   logic [2:0]      state_ff, state_in;
   logic [OccW-1:0] occ_ff, occ_in;
   logic [IdxW-1:0] head_ff, head_in;
   logic [IdxW-1:0] tail_ff, tail_in;
   logic            halt_ff, halt_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [IdxW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   key_type         key_ff, key_in;
   logic            crit_ff, crit_in;
   count_type       count_ff, count_in;

   // finished result, waiting for the output register
   logic            pend_matched_ff, pend_matched_in;
   logic [IdxW-1:0] pend_slot_ff, pend_slot_in;
   count_type       pend_occ_ff, pend_occ_in;
   logic            pend_evicted_ff, pend_evicted_in;
   logic [OccW-1:0] pend_used_ff, pend_used_in;
   logic            pend_halted_ff, pend_halted_in;

   // output register payload
   logic            rsp_matched_ff, rsp_matched_in;
   logic [3:0]      rsp_slot_ff, rsp_slot_in;
   count_type       rsp_occ_ff, rsp_occ_in;
   logic            rsp_evicted_ff, rsp_evicted_in;
   logic [3:0]      rsp_used_ff, rsp_used_in;
   logic            rsp_halted_ff, rsp_halted_in;

   // RAM port
   logic            wr_en;
   logic [IdxW-1:0] wr_addr;
   record_type      wr_rec;
   logic [IdxW-1:0] rd_addr;
   record_type      rd_rec;

   logic            out_free;
   logic            scan_last;
   logic [IdxW+3:0] slot_wide;
   logic [OccW+3:0] used_wide;
   key_type         req_key;

   fldt_ram #(
      .Width(RecW),
      .Depth(MAX_ENTRIES)
   ) u_rec_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_rec),
      .rd_addr(rd_addr),
      .rd_data(rd_rec)
   );

   assign req_key   = {req_module_id, req_fault_code, req_line_number, req_extra_word};
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign scan_last = (OccW'(idx_ff) == (occ_ff - OccW'(1)));
   // slot and entries_used are reported modulo 16
   assign slot_wide = {4'b0000, pend_slot_ff};
   assign used_wide = {4'b0000, pend_used_ff};
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in        = state_ff;
      occ_in          = occ_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      halt_in         = halt_ff;
      rd_ptr_in       = rd_ptr_ff;
      idx_in          = idx_ff;
      key_in          = key_ff;
      crit_in         = crit_ff;
      count_in        = count_ff;
      pend_matched_in = pend_matched_ff;
      pend_slot_in    = pend_slot_ff;
      pend_occ_in     = pend_occ_ff;
      pend_evicted_in = pend_evicted_ff;
      pend_used_in    = pend_used_ff;
      pend_halted_in  = pend_halted_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_matched_in  = rsp_matched_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_occ_in      = rsp_occ_ff;
      rsp_evicted_in  = rsp_evicted_ff;
      rsp_used_in     = rsp_used_ff;
      rsp_halted_in   = rsp_halted_ff;
      wr_en           = 1'b0;
      wr_addr         = tail_ff;
      wr_rec.key      = key_ff;
      wr_rec.count    = count_type'(1);
      rd_addr         = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pend_matched_in = 1'b0;
               pend_slot_in    = '0;
               pend_occ_in     = '0;
               pend_evicted_in = 1'b0;
               if (halt_ff) begin
                  pend_used_in   = occ_ff;
                  pend_halted_in = 1'b1;
                  state_in       = ST_DONE;
               end else if (req_kind) begin
                  occ_in         = '0;
                  head_in        = '0;
                  tail_in        = '0;
                  pend_used_in   = '0;
                  pend_halted_in = 1'b0;
                  state_in       = ST_DONE;
               end else begin
                  key_in    = req_key;
                  crit_in   = req_critical;
                  idx_in    = '0;
                  rd_ptr_in = head_ff;
                  // RAM read of the oldest record is issued this cycle
                  state_in  = (occ_ff == '0) ? ST_APPEND : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // prefetch the following record while this one is compared
            rd_addr = ring_next(rd_ptr_ff);
            if (rd_rec.key == key_ff) begin
               count_in = rd_rec.count;
               state_in = ST_UPDATE;
            end else if (scan_last) begin
               state_in = ST_APPEND;
            end else begin
               idx_in    = idx_ff + IdxW'(1);
               rd_ptr_in = ring_next(rd_ptr_ff);
            end
         end
         ST_UPDATE: begin
            wr_en           = 1'b1;
            wr_addr         = rd_ptr_ff;
            wr_rec.count    = count_ff + count_type'(1);
            pend_matched_in = 1'b1;
            pend_slot_in    = idx_ff;
            pend_occ_in     = count_ff + count_type'(1);
            pend_evicted_in = 1'b0;
            pend_used_in    = occ_ff;
            pend_halted_in  = halt_ff || crit_ff;
            halt_in         = halt_ff || crit_ff;
            state_in        = ST_DONE;
         end
         ST_APPEND: begin
            wr_en           = 1'b1;
            tail_in         = ring_next(tail_ff);
            pend_matched_in = 1'b0;
            pend_occ_in     = count_type'(1);
            pend_halted_in  = halt_ff || crit_ff;
            halt_in         = halt_ff || crit_ff;
            if (occ_ff == FullOcc) begin
               // full ring: tail sits on the oldest record, overwrite it
               head_in         = ring_next(head_ff);
               pend_evicted_in = 1'b1;
               pend_slot_in    = LastIdx;
               pend_used_in    = occ_ff;
            end else begin
               occ_in          = occ_ff + OccW'(1);
               pend_evicted_in = 1'b0;
               pend_slot_in    = IdxW'(occ_ff);
               pend_used_in    = occ_ff + OccW'(1);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_matched_in = pend_matched_ff;
               rsp_slot_in    = slot_wide[3:0];
               rsp_occ_in     = pend_occ_ff;
               rsp_evicted_in = pend_evicted_ff;
               rsp_used_in    = used_wide[3:0];
               rsp_halted_in  = pend_halted_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         halt_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         halt_ff      <= halt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff       <= rd_ptr_in;
      idx_ff          <= idx_in;
      key_ff          <= key_in;
      crit_ff         <= crit_in;
      count_ff        <= count_in;
      pend_matched_ff <= pend_matched_in;
      pend_slot_ff    <= pend_slot_in;
      pend_occ_ff     <= pend_occ_in;
      pend_evicted_ff <= pend_evicted_in;
      pend_used_ff    <= pend_used_in;
      pend_halted_ff  <= pend_halted_in;
      rsp_matched_ff  <= rsp_matched_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_occ_ff      <= rsp_occ_in;
      rsp_evicted_ff  <= rsp_evicted_in;
      rsp_used_ff     <= rsp_used_in;
      rsp_halted_ff   <= rsp_halted_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_matched      = rsp_matched_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_occurrences  = rsp_occ_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_entries_used = rsp_used_ff;
   assign rsp_halted       = rsp_halted_ff;

   // fill count never exceeds the ring size
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= FullOcc)
      else $error("fill count above ring size");

   // head and tail coincide exactly when the ring is empty or full
   a_ring_ptrs: assert property (@(posedge clock) disable iff (reset)
      ((occ_ff == FullOcc) || (occ_ff == '0)) |-> (head_ff == tail_ff))
      else $error("ring pointers out of step with fill count");

   // halt is sticky until reset
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("halt dropped without reset");

   // a matched word never evicts
   a_match_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_matched_ff) |-> !rsp_evicted_ff)
      else $error("matched word flagged an eviction");

endmodule

### dv/fault_log_dedup_table_core_test.sv
// Testbench for fault_log_dedup_table_core: directed rows, random fault words, halt rows;
// results checked against table rows or a log model. Depends on fldt_pkg and the RTL.
`timescale 1ns / 1ps

module fault_log_dedup_table_core_test
   import fldt_pkg::*;
();

   localparam int LogDepth     = 10;
   localparam int RandomWords  = 1850;
   localparam int CycleLimit   = 400000;
   localparam int PoolSize     = 14;
   localparam int DrainCycles  = 30;

   typedef enum logic {KIND_REPORT = 1'b0, KIND_CLEAR = 1'b1} word_kind_type;

   typedef struct {
      word_kind_type kind;
      logic [7:0]    module_id;
      logic [7:0]    fault_code;
      logic [15:0]   line_number;
      logic [31:0]   extra_word;
      logic          critical;
   } fault_word_type;

   typedef struct {
      logic        matched;
      logic [3:0]  slot;
      count_type   occurrences;
      logic        evicted;
      logic [3:0]  entries_used;
      logic        halted;
   } outcome_type;

   typedef struct {
      fault_word_type word;
      bit             typed;
      outcome_type    outcome;
   } table_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_kind;
   logic [7:0]  req_module_id;
   logic [7:0]  req_fault_code;
   logic [15:0] req_line_number;
   logic [31:0] req_extra_word;
   logic        req_critical;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_matched;
   logic [3:0]  rsp_slot;
   logic [31:0] rsp_occurrences;
   logic        rsp_evicted;
   logic [3:0]  rsp_entries_used;
   logic        rsp_halted;

   fault_log_dedup_table_core #(.MAX_ENTRIES(LogDepth)) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_module_id    (req_module_id),
      .req_fault_code   (req_fault_code),
      .req_line_number  (req_line_number),
      .req_extra_word   (req_extra_word),
      .req_critical     (req_critical),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_matched      (rsp_matched),
      .rsp_slot         (rsp_slot),
      .rsp_occurrences  (rsp_occurrences),
      .rsp_evicted      (rsp_evicted),
      .rsp_entries_used (rsp_entries_used),
      .rsp_halted       (rsp_halted)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // model of the log
   key_type   model_keys   [LogDepth];
   count_type model_counts [LogDepth];
   int        model_fill;
   bit        model_halt;

   outcome_type   pending_outcomes [$];
   table_row_type opening_rows [$];
   table_row_type halt_rows [$];
   key_type       key_pool [PoolSize];
   int            error_count = 0;
   int            burst_left;

   function automatic key_type key_of(fault_word_type w);
      return {w.module_id, w.fault_code, w.line_number, w.extra_word};
   endfunction

   function automatic fault_word_type fault_word(word_kind_type kind, logic [7:0] module_id,
         logic [7:0] fault_code, logic [15:0] line_number, logic [31:0] extra_word,
         logic critical);
      fault_word_type w;
      w.kind        = kind;
      w.module_id   = module_id;
      w.fault_code  = fault_code;
      w.line_number = line_number;
      w.extra_word  = extra_word;
      w.critical    = critical;
      return w;
   endfunction

   function automatic fault_word_type word_from_key(word_kind_type kind, key_type k,
         logic critical);
      return fault_word(kind, k[63:56], k[55:48], k[47:32], k[31:0], critical);
   endfunction

   function automatic outcome_type outcome(logic matched, logic [3:0] slot, count_type occ,
         logic evicted, logic [3:0] used, logic halted);
      outcome_type o;
      o.matched      = matched;
      o.slot         = slot;
      o.occurrences  = occ;
      o.evicted      = evicted;
      o.entries_used = used;
      o.halted       = halted;
      return o;
   endfunction

   function automatic table_row_type row(fault_word_type w);
      table_row_type r;
      r.word    = w;
      r.typed   = 1'b0;
      r.outcome = outcome(0, 0, 0, 0, 0, 0);
      return r;
   endfunction

   function automatic table_row_type checked_row(fault_word_type w, outcome_type o);
      table_row_type r;
      r.word    = w;
      r.typed   = 1'b1;
      r.outcome = o;
      return r;
   endfunction

   function automatic void append_row(ref table_row_type q[$], input table_row_type r);
      q.insert(q.size(), r);
   endfunction

   // Applies one word to the model log and returns the result it must produce.
   function automatic outcome_type log_fault_word(fault_word_type w);
      key_type k;
      int      pos;
      bit      found;
      bit      dropped;
      k       = key_of(w);
      pos     = 0;
      found   = 1'b0;
      dropped = 1'b0;
      if (model_halt)
         return outcome(0, 0, 0, 0, 4'(model_fill), 1'b1);
      if (w.kind == KIND_CLEAR) begin
         model_fill = 0;
         return outcome(0, 0, 0, 0, 0, 1'b0);
      end
      for (int i = 0; i < model_fill; i++) begin
         if (!found && model_keys[i] == k) begin
            found = 1'b1;
            pos   = i;
         end
      end
      if (found) begin
         model_counts[pos] = model_counts[pos] + count_type'(1);
      end else begin
         if (model_fill == LogDepth) begin
            for (int i = 1; i < LogDepth; i++) begin
               model_keys[i-1]   = model_keys[i];
               model_counts[i-1] = model_counts[i];
            end
            model_fill = LogDepth - 1;
            dropped    = 1'b1;
         end
         pos               = model_fill;
         model_keys[pos]   = k;
         model_counts[pos] = count_type'(1);
         model_fill++;
      end
      if (w.critical)
         model_halt = 1'b1;
      return outcome(found, 4'(pos), model_counts[pos], dropped, 4'(model_fill), model_halt);
   endfunction

   task automatic send_word(fault_word_type w, bit typed, outcome_type typed_outcome);
      outcome_type predicted;
      req_valid       <= 1'b1;
      req_kind        <= w.kind;
      req_module_id   <= w.module_id;
      req_fault_code  <= w.fault_code;
      req_line_number <= w.line_number;
      req_extra_word  <= w.extra_word;
      req_critical    <= w.critical;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predicted = log_fault_word(w);
      pending_outcomes.insert(pending_outcomes.size(), typed ? typed_outcome : predicted);
      // bursts of back-to-back words, then usually an idle gap
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
   endtask

   task automatic compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, act_val);
         error_count++;
      end
   endtask

   // result side: check accepted words, stall on a pattern of its own
   int  stall_mode = 0;
   int  mode_left = 0;
   int  stall_phase = 0;

   always @(posedge clock) begin
      outcome_type exp_o;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected result word, expected none, got slot %0h occ %0h",
                     $time, rsp_slot, rsp_occurrences);
            error_count++;
         end else begin
            exp_o = pending_outcomes.pop_front();
            compare_field("matched", 32'(exp_o.matched), 32'(rsp_matched));
            compare_field("slot", 32'(exp_o.slot), 32'(rsp_slot));
            compare_field("occurrences", exp_o.occurrences, rsp_occurrences);
            compare_field("evicted", 32'(exp_o.evicted), 32'(rsp_evicted));
            compare_field("entries_used", 32'(exp_o.entries_used), 32'(rsp_entries_used));
            compare_field("halted", 32'(exp_o.halted), 32'(rsp_halted));
         end
      end
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(32, 256);
      end else begin
         mode_left--;
      end
      stall_phase = (stall_phase + 1) % 7;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 2) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= (stall_phase < 3);
      endcase
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("fault_log_dedup_table_core_test: done, errors");
      $finish;
   end

   initial begin
      fault_word_type w;
      key_type        k;
      int             pick;
      burst_left  = 0;
      model_fill  = 0;
      model_halt  = 1'b0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_kind        <= KIND_REPORT;
      req_module_id   <= 8'h00;
      req_fault_code  <= 8'h00;
      req_line_number <= 16'h0000;
      req_extra_word  <= 32'h0;
      req_critical    <= 1'b0;

      append_row(opening_rows, checked_row(fault_word(KIND_REPORT, 8'h00, 8'h00, 16'h0000,
         32'h0, 1'b0), outcome(0, 0, 1, 0, 1, 0)));
      append_row(opening_rows, checked_row(fault_word(KIND_REPORT, 8'h00, 8'h00, 16'h0000,
         32'h0, 1'b0), outcome(1, 0, 2, 0, 1, 0)));
      append_row(opening_rows, checked_row(fault_word(KIND_REPORT, 8'hFF, 8'hFF, 16'hFFFF,
         32'hFFFF_FFFF, 1'b0), outcome(0, 1, 1, 0, 2, 0)));
      // differs from the first key in one bit only
      append_row(opening_rows, row(fault_word(KIND_REPORT, 8'h00, 8'h00, 16'h0000,
         32'h1, 1'b0)));
      // clear ignores its critical bit
      append_row(opening_rows, checked_row(fault_word(KIND_CLEAR, 8'hFF, 8'hFF, 16'hFFFF,
         32'hFFFF_FFFF, 1'b1), outcome(0, 0, 0, 0, 0, 0)));
      append_row(opening_rows, checked_row(fault_word(KIND_REPORT, 8'h00, 8'h00, 16'h0000,
         32'h0, 1'b0), outcome(0, 0, 1, 0, 1, 0)));
      for (int i = 1; i <= 9; i++)
         append_row(opening_rows, row(fault_word(KIND_REPORT, 8'(i), 8'h5A,
            16'h8000 | 16'(i), 32'hA5A5_0000 + 32'(i), 1'b0)));
      // full log: oldest dropped
      append_row(opening_rows, checked_row(fault_word(KIND_REPORT, 8'hC3, 8'h3C, 16'h7FFF,
         32'h8000_0000, 1'b0), outcome(0, 9, 1, 1, 10, 0)));
      append_row(opening_rows, row(fault_word(KIND_REPORT, 8'h01, 8'h5A, 16'h8001,
         32'hA5A5_0001, 1'b0)));
      append_row(opening_rows, row(fault_word(KIND_REPORT, 8'h00, 8'h00, 16'h0000,
         32'h0, 1'b0)));
      append_row(opening_rows, checked_row(fault_word(KIND_CLEAR, 8'h00, 8'h00, 16'h0000,
         32'h0, 1'b0), outcome(0, 0, 0, 0, 0, 0)));

      // halt is sticky until reset, so it comes last
      append_row(halt_rows, checked_row(fault_word(KIND_CLEAR, 8'h00, 8'h00, 16'h0000,
         32'h0, 1'b0), outcome(0, 0, 0, 0, 0, 0)));
      append_row(halt_rows, checked_row(fault_word(KIND_REPORT, 8'h7E, 8'h01, 16'h1234,
         32'hDEAD_BEEF, 1'b0), outcome(0, 0, 1, 0, 1, 0)));
      append_row(halt_rows, checked_row(fault_word(KIND_REPORT, 8'h7E, 8'h01, 16'h1234,
         32'hDEAD_BEEF, 1'b1), outcome(1, 0, 2, 0, 1, 1)));
      append_row(halt_rows, checked_row(fault_word(KIND_REPORT, 8'h81, 8'hFE, 16'hEDCB,
         32'h2152_4110, 1'b0), outcome(0, 0, 0, 0, 1, 1)));
      append_row(halt_rows, checked_row(fault_word(KIND_CLEAR, 8'h00, 8'h00, 16'h0000,
         32'h0, 1'b0), outcome(0, 0, 0, 0, 1, 1)));
      append_row(halt_rows, checked_row(fault_word(KIND_REPORT, 8'h7E, 8'h01, 16'h1234,
         32'hDEAD_BEEF, 1'b1), outcome(0, 0, 0, 0, 1, 1)));

      for (int i = 0; i < PoolSize; i++)
         key_pool[i] = {$urandom, $urandom};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening_rows[i])
         send_word(opening_rows[i].word, opening_rows[i].typed, opening_rows[i].outcome);

      // pool larger than the log: repeats match, cycling keys evict
      for (int n = 0; n < RandomWords; n++) begin
         pick = $urandom_range(0, 99);
         k    = key_pool[$urandom_range(0, PoolSize - 1)];
         if (pick < 2) begin
            w = word_from_key(KIND_CLEAR, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
         end else if (pick < 72) begin
            w = word_from_key(KIND_REPORT, k, 1'b0);
         end else if (pick < 87) begin
            w = word_from_key(KIND_REPORT, k ^ (64'd1 << $urandom_range(0, 63)), 1'b0);
         end else begin
            w = word_from_key(KIND_REPORT, {$urandom, $urandom}, 1'b0);
         end
         if ($urandom_range(0, 99) == 0)
            key_pool[$urandom_range(0, PoolSize - 1)] = {$urandom, $urandom};
         send_word(w, 1'b0, outcome(0, 0, 0, 0, 0, 0));
      end

      foreach (halt_rows[i])
         send_word(halt_rows[i].word, halt_rows[i].typed, halt_rows[i].outcome);
      req_valid <= 1'b0;

      while (pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (error_count == 0)
         $display("fault_log_dedup_table_core_test: done, clean");
      else
         $display("fault_log_dedup_table_core_test: done, errors");
      $finish;
   end

endmodule

### filelist.f
rtl/fldt_pkg.sv
rtl/fldt_ram.sv
rtl/fault_log_dedup_table_core.sv
dv/fault_log_dedup_table_core_test.sv
